/* design/clpd_pkg.sv */
// clpd_pkg: shared types, codes and constants of the corner long press detector
// no dependencies; used by the top level, the port checker and the testbench

package clpd_pkg;

    // operation field of an input transaction
    localparam int unsigned OP_W = 3;
    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_POS_X      = 3'd0;
    localparam op_t OP_POS_Y      = 3'd1;
    localparam op_t OP_TOUCH_DOWN = 3'd2;
    localparam op_t OP_TOUCH_UP   = 3'd3;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_HOLD_MIN_MS  = 3'd0;
    localparam cfg_index_t REG_SLOP_LIMIT   = 3'd1;
    localparam cfg_index_t REG_REGION_X_MAX = 3'd2;
    localparam cfg_index_t REG_REGION_Y_MAX = 3'd3;
    localparam cfg_index_t REG_COOLDOWN_MS  = 3'd4;

    // register widths
    localparam int unsigned MS_W    = 16;
    localparam int unsigned LIMIT_W = 12;
    typedef logic [MS_W-1:0]    ms_t;
    typedef logic [LIMIT_W-1:0] limit_t;

    // register reset values
    localparam ms_t    HOLD_MIN_MS_RST  = 16'd900;
    localparam limit_t SLOP_LIMIT_RST   = 12'd24;
    localparam limit_t REGION_X_MAX_RST = 12'd80;
    localparam limit_t REGION_Y_MAX_RST = 12'd90;
    localparam ms_t    COOLDOWN_MS_RST  = 16'd1500;

    // result transaction: fire in bit 0, padded to one byte
    localparam int unsigned OUT_DATA_W = 8;

endpackage

/* design/corner_long_press_detector_top.sv */
// corner_long_press_detector_top: long press detector for touches starting in a panel corner
// depends on clpd_pkg
// path from input transaction to result: input register, then result register
// one event per cycle without stalls; the next event reads the state left by the previous one
// while a result waits downstream one more event is taken into the input register
// reset: asynchronous active low; clears valid flags, tracking state and loads register defaults

module corner_long_press_detector_top #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned TIME_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  clpd_pkg::cfg_index_t            cfg_index,
    input  logic [clpd_pkg::CFG_DATA_W-1:0] cfg_data,
    // touch events
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // fields from bit 0: coordinate, time_ms, context_ok, zero fill
    input  logic [((COORD_BITS+TIME_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    // fields from bit 0: operation
    input  clpd_pkg::op_t                   s_axis_tuser,
    // results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fields from bit 0: fire, zero fill
    output logic [clpd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int unsigned CMP_W     =
        (COORD_BITS > clpd_pkg::LIMIT_W) ? COORD_BITS : clpd_pkg::LIMIT_W;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [TIME_BITS-1:0]  tstamp_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    // configuration registers
    clpd_pkg::ms_t    hold_min_ms_reg;
    clpd_pkg::limit_t slop_limit_reg;
    clpd_pkg::limit_t region_x_max_reg;
    clpd_pkg::limit_t region_y_max_reg;
    clpd_pkg::ms_t    cooldown_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_min_ms_reg  <= clpd_pkg::HOLD_MIN_MS_RST;
            slop_limit_reg   <= clpd_pkg::SLOP_LIMIT_RST;
            region_x_max_reg <= clpd_pkg::REGION_X_MAX_RST;
            region_y_max_reg <= clpd_pkg::REGION_Y_MAX_RST;
            cooldown_ms_reg  <= clpd_pkg::COOLDOWN_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                clpd_pkg::REG_HOLD_MIN_MS:
                    hold_min_ms_reg <= cfg_data[clpd_pkg::MS_W-1:0];
                clpd_pkg::REG_SLOP_LIMIT:
                    slop_limit_reg <= cfg_data[clpd_pkg::LIMIT_W-1:0];
                clpd_pkg::REG_REGION_X_MAX:
                    region_x_max_reg <= cfg_data[clpd_pkg::LIMIT_W-1:0];
                clpd_pkg::REG_REGION_Y_MAX:
                    region_y_max_reg <= cfg_data[clpd_pkg::LIMIT_W-1:0];
                clpd_pkg::REG_COOLDOWN_MS:
                    cooldown_ms_reg <= cfg_data[clpd_pkg::MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register and result register handshake
    logic          in_valid_reg;
    clpd_pkg::op_t op_reg;
    coord_t        coord_reg;
    tstamp_t       time_reg;
    logic          ctx_reg;
    logic          out_valid_reg;
    logic          fire_reg;
    logic          advance;
    logic          in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // capture the event payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= s_axis_tuser;
            coord_reg <= s_axis_tdata[COORD_BITS-1:0];
            time_reg  <= s_axis_tdata[COORD_BITS +: TIME_BITS];
            ctx_reg   <= s_axis_tdata[COORD_BITS + TIME_BITS];
        end
    end

    // tracking state
    coord_t  cur_x_reg,  cur_x_next;
    coord_t  cur_y_reg,  cur_y_next;
    logic    cur_x_known_reg, cur_x_known_next;
    logic    cur_y_known_reg, cur_y_known_next;
    coord_t  start_px_reg, start_px_next;
    coord_t  start_py_reg, start_py_next;
    logic    start_known_reg, start_known_next;
    logic    pressed_reg, pressed_next;
    logic    in_region_reg, in_region_next;
    logic    moved_far_reg, moved_far_next;
    tstamp_t press_time_reg, press_time_next;
    tstamp_t last_fire_reg, last_fire_next;
    logic    fire_next;

    // per-axis distance compare against the slop limit
    cmp_t    slop_ext;
    cmp_t    new_x, new_y, sx, sy;
    cmp_t    dx, dy;
    logic    slop_exceeded;
    logic    pos_x_known, pos_y_known;
    tstamp_t held, since;
    logic    hold_ok, cool_ok;

    always_comb
    begin
        slop_ext    = cmp_t'(slop_limit_reg);
        new_x       = (op_reg == clpd_pkg::OP_POS_X) ? cmp_t'(coord_reg) : cmp_t'(cur_x_reg);
        new_y       = (op_reg == clpd_pkg::OP_POS_Y) ? cmp_t'(coord_reg) : cmp_t'(cur_y_reg);
        sx          = cmp_t'(start_px_reg);
        sy          = cmp_t'(start_py_reg);
        dx          = (new_x >= sx) ? (new_x - sx) : (sx - new_x);
        dy          = (new_y >= sy) ? (new_y - sy) : (sy - new_y);
        pos_x_known = (op_reg == clpd_pkg::OP_POS_X) || cur_x_known_reg;
        pos_y_known = (op_reg == clpd_pkg::OP_POS_Y) || cur_y_known_reg;
        slop_exceeded = pressed_reg && start_known_reg && pos_x_known && pos_y_known
                        && ((dx > slop_ext) || (dy > slop_ext));
    end

    // hold and cooldown checks, differences wrap at the timestamp width
    always_comb
    begin
        held    = time_reg - press_time_reg;
        since   = time_reg - last_fire_reg;
        hold_ok = held >= tstamp_t'(hold_min_ms_reg);
        cool_ok = since >= tstamp_t'(cooldown_ms_reg);
    end

    // next state for the event in the input register
    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        cur_x_known_next = cur_x_known_reg;
        cur_y_known_next = cur_y_known_reg;
        start_px_next    = start_px_reg;
        start_py_next    = start_py_reg;
        start_known_next = start_known_reg;
        pressed_next     = pressed_reg;
        in_region_next   = in_region_reg;
        moved_far_next   = moved_far_reg;
        press_time_next  = press_time_reg;
        last_fire_next   = last_fire_reg;
        fire_next        = 1'b0;
        unique case (op_reg)
            clpd_pkg::OP_POS_X:
            begin
                cur_x_next       = coord_reg;
                cur_x_known_next = 1'b1;
                if (slop_exceeded)
                begin
                    moved_far_next = 1'b1;
                end
            end
            clpd_pkg::OP_POS_Y:
            begin
                cur_y_next       = coord_reg;
                cur_y_known_next = 1'b1;
                if (slop_exceeded)
                begin
                    moved_far_next = 1'b1;
                end
            end
            clpd_pkg::OP_TOUCH_DOWN:
            begin
                pressed_next     = 1'b1;
                press_time_next  = time_reg;
                start_px_next    = cur_x_reg;
                start_py_next    = cur_y_reg;
                start_known_next = cur_x_known_reg && cur_y_known_reg;
                moved_far_next   = 1'b0;
                in_region_next   = cur_x_known_reg && cur_y_known_reg
                                   && (cmp_t'(cur_x_reg) <= cmp_t'(region_x_max_reg))
                                   && (cmp_t'(cur_y_reg) <= cmp_t'(region_y_max_reg));
            end
            clpd_pkg::OP_TOUCH_UP:
            begin
                if (pressed_reg && in_region_reg && !moved_far_reg && start_known_reg
                    && hold_ok && cool_ok && ctx_reg)
                begin
                    fire_next      = 1'b1;
                    last_fire_next = time_reg;
                end
                pressed_next     = 1'b0;
                in_region_next   = 1'b0;
                moved_far_next   = 1'b0;
                start_known_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // tracking state update when the event moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            cur_x_known_reg <= 1'b0;
            cur_y_known_reg <= 1'b0;
            start_px_reg    <= '0;
            start_py_reg    <= '0;
            start_known_reg <= 1'b0;
            pressed_reg     <= 1'b0;
            in_region_reg   <= 1'b0;
            moved_far_reg   <= 1'b0;
            press_time_reg  <= '0;
            last_fire_reg   <= '0;
        end
        else if (advance)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            cur_x_known_reg <= cur_x_known_next;
            cur_y_known_reg <= cur_y_known_next;
            start_px_reg    <= start_px_next;
            start_py_reg    <= start_py_next;
            start_known_reg <= start_known_next;
            pressed_reg     <= pressed_next;
            in_region_reg   <= in_region_next;
            moved_far_reg   <= moved_far_next;
            press_time_reg  <= press_time_next;
            last_fire_reg   <= last_fire_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fire_reg <= fire_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(clpd_pkg::OUT_DATA_W-1){1'b0}}, fire_reg};

endmodule

/* design/clpd_checker.sv */
// clpd_checker: port-level checks of the corner long press detector
// depends on clpd_pkg; bound to corner_long_press_detector_top below

module clpd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [clpd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result transaction keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

    // input only stalls when a result is waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

    // an accepted event is followed by a valid result on the output, its own or a stalled earlier one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted event");

    // only the fire bit may be set in a result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> 1) == '0)
    else $error("fill bits of result set");

endmodule

bind corner_long_press_detector_top clpd_checker u_clpd_checker (.*);

/* tb/tb_corner_long_press_detector_top.sv */
// testbench for corner_long_press_detector_top: directed gestures, then random sessions
// under several register settings, each fire bit checked against an in-bench predictor
// depends on clpd_pkg and corner_long_press_detector_top
`timescale 1ns / 1ps

module tb_corner_long_press_detector_top;

    localparam int COORD_W  = 12;
    localparam int TIME_W   = 32;
    localparam int TDATA_W  = 48;
    localparam int MAX_COORD = 4095;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;

    // operation codes that the block ignores
    localparam clpd_pkg::op_t OP_NOP_LO = 3'd4;
    localparam clpd_pkg::op_t OP_NOP_HI = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    clpd_pkg::cfg_index_t            cfg_index = '0;
    logic [clpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // coordinate, time_ms, context_ok, zero fill
    logic [TDATA_W-1:0]              s_axis_tdata = '0;
    // operation
    clpd_pkg::op_t                   s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // fire, zero fill
    logic [clpd_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    corner_long_press_detector_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // register copies
    clpd_pkg::ms_t    hold_min   = clpd_pkg::HOLD_MIN_MS_RST;
    clpd_pkg::limit_t slop_limit = clpd_pkg::SLOP_LIMIT_RST;
    clpd_pkg::limit_t region_x   = clpd_pkg::REGION_X_MAX_RST;
    clpd_pkg::limit_t region_y   = clpd_pkg::REGION_Y_MAX_RST;
    clpd_pkg::ms_t    cooldown   = clpd_pkg::COOLDOWN_MS_RST;

    // gesture tracking state
    logic [COORD_W-1:0] pos_x = '0;
    logic               pos_x_known = 1'b0;
    logic [COORD_W-1:0] pos_y = '0;
    logic               pos_y_known = 1'b0;
    logic [COORD_W-1:0] anchor_x = '0;
    logic [COORD_W-1:0] anchor_y = '0;
    logic               anchor_known = 1'b0;
    logic               pressed = 1'b0;
    logic               in_corner = 1'b0;
    logic               spoiled = 1'b0;
    logic [TIME_W-1:0]  press_stamp = '0;
    logic [TIME_W-1:0]  last_fire_stamp = '0;

    logic fire_expected[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   in_idle_pct = 34;
    int   out_idle_pct = 34;
    logic [TIME_W-1:0] now_ms = '0;

    function automatic logic [COORD_W-1:0] coord_dist(logic [COORD_W-1:0] a,
                                                       logic [COORD_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // movement beyond the slop on either axis spoils the press
    function automatic void check_drift();
        if (pressed && anchor_known && pos_x_known && pos_y_known)
        begin
            if (coord_dist(pos_x, anchor_x) > slop_limit ||
                coord_dist(pos_y, anchor_y) > slop_limit)
                spoiled = 1'b1;
        end
    endfunction

    // advance the gesture state by one event and return its fire bit
    function automatic logic predict_fire(clpd_pkg::op_t op, logic [COORD_W-1:0] coord,
                                          logic [TIME_W-1:0] stamp, logic ctx);
        logic              fire;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] since;
        fire = 1'b0;
        case (op)
            clpd_pkg::OP_POS_X:
            begin
                pos_x = coord;
                pos_x_known = 1'b1;
                check_drift();
            end
            clpd_pkg::OP_POS_Y:
            begin
                pos_y = coord;
                pos_y_known = 1'b1;
                check_drift();
            end
            clpd_pkg::OP_TOUCH_DOWN:
            begin
                pressed = 1'b1;
                press_stamp = stamp;
                anchor_x = pos_x;
                anchor_y = pos_y;
                anchor_known = pos_x_known && pos_y_known;
                spoiled = 1'b0;
                in_corner = anchor_known && pos_x <= region_x && pos_y <= region_y;
            end
            clpd_pkg::OP_TOUCH_UP:
            begin
                if (pressed && in_corner && !spoiled && anchor_known)
                begin
                    held = stamp - press_stamp;
                    since = stamp - last_fire_stamp;
                    if (held >= hold_min && since >= cooldown && ctx)
                    begin
                        fire = 1'b1;
                        last_fire_stamp = stamp;
                    end
                end
                pressed = 1'b0;
                in_corner = 1'b0;
                spoiled = 1'b0;
                anchor_known = 1'b0;
            end
            default: ;
        endcase
        return fire;
    endfunction

    // send one touch event; tvalid stays high after acceptance for a back-to-back event
    task automatic send_event(input clpd_pkg::op_t op, input logic [COORD_W-1:0] coord,
                              input logic [TIME_W-1:0] stamp, input logic ctx);
        while ($urandom_range(99) < in_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, ctx, stamp, coord};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        fire_expected.push_back(predict_fire(op, coord, stamp, ctx));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (fire_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all five registers while the block is idle
    task automatic apply_settings(input clpd_pkg::ms_t hold, input clpd_pkg::limit_t slop,
                                  input clpd_pkg::limit_t rx, input clpd_pkg::limit_t ry,
                                  input clpd_pkg::ms_t cool);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= clpd_pkg::REG_HOLD_MIN_MS;
        cfg_data <= hold;
        @(posedge clk);
        cfg_index <= clpd_pkg::REG_SLOP_LIMIT;
        cfg_data <= clpd_pkg::CFG_DATA_W'(slop);
        @(posedge clk);
        cfg_index <= clpd_pkg::REG_REGION_X_MAX;
        cfg_data <= clpd_pkg::CFG_DATA_W'(rx);
        @(posedge clk);
        cfg_index <= clpd_pkg::REG_REGION_Y_MAX;
        cfg_data <= clpd_pkg::CFG_DATA_W'(ry);
        @(posedge clk);
        cfg_index <= clpd_pkg::REG_COOLDOWN_MS;
        cfg_data <= cool;
        @(posedge clk);
        cfg_we <= 1'b0;
        hold_min = hold;
        slop_limit = slop;
        region_x = rx;
        region_y = ry;
        cooldown = cool;
    endtask

    // press with no known position, then with only x known
    task automatic test_unknown_position();
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd0, 1'b1);
        send_event(clpd_pkg::OP_POS_X, 12'd10, 32'd50, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd100, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd5000, 1'b1);
    endtask

    // cooldown after reset counts from time zero
    task automatic test_first_fire_cooldown();
        send_event(clpd_pkg::OP_POS_Y, 12'd20, 32'd200, 1'b0);
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd300, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd1400, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd1000, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd2000, 1'b1);
    endtask

    // unknown codes inside a valid press change nothing
    task automatic test_ignored_ops();
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd4000, 1'b1);
        send_event(OP_NOP_LO, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(OP_NOP_HI, 12'hFFF, 32'hFFFF_FFFF, 1'b0);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd5000, 1'b1);
    endtask

    task automatic test_release_unpressed();
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd9000, 1'b1);
    endtask

    // a second touch down restarts the hold timer
    task automatic test_restart_press();
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd10000, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd10800, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd11500, 1'b1);
    endtask

    // movement exactly at the slop keeps the press, one more spoils it
    task automatic test_slop();
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd20000, 1'b1);
        send_event(clpd_pkg::OP_POS_X, 12'd34, 32'd20100, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd21000, 1'b1);
        send_event(clpd_pkg::OP_POS_X, 12'd10, 32'd29000, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'd30000, 1'b1);
        send_event(clpd_pkg::OP_POS_Y, 12'd45, 32'd30100, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'd31000, 1'b1);
    endtask

    // hold time across the timestamp wrap
    task automatic test_time_wrap();
        send_event(clpd_pkg::OP_POS_X, 12'd0, 32'hFFFF_FE00, 1'b0);
        send_event(clpd_pkg::OP_POS_Y, 12'd0, 32'hFFFF_FE80, 1'b0);
        send_event(clpd_pkg::OP_TOUCH_DOWN, 12'd0, 32'hFFFF_FF00, 1'b1);
        send_event(clpd_pkg::OP_TOUCH_UP, 12'd0, 32'h0000_0400, 1'b1);
    endtask

    // mostly well-formed press sessions with random content, plus noise
    task automatic run_gestures(input int count);
        int            sent;
        int            sx;
        int            sy;
        int            p;
        int            moves;
        int            delta;
        logic          axis;
        clpd_pkg::op_t op;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(3) != 0)
                begin
                    sx = $urandom_range(int'(region_x));
                    sy = $urandom_range(int'(region_y));
                end
                else
                begin
                    sx = $urandom_range(MAX_COORD);
                    sy = $urandom_range(MAX_COORD);
                end
                send_event(clpd_pkg::OP_POS_X, COORD_W'(sx), now_ms, 1'($urandom_range(1)));
                send_event(clpd_pkg::OP_POS_Y, COORD_W'(sy), now_ms, 1'($urandom_range(1)));
                now_ms = now_ms + TIME_W'($urandom_range(int'(cooldown) + 100));
                send_event(clpd_pkg::OP_TOUCH_DOWN, COORD_W'($urandom_range(MAX_COORD)),
                           now_ms, 1'($urandom_range(1)));
                moves = $urandom_range(3);
                repeat (moves)
                begin
                    axis = 1'($urandom_range(1));
                    p = (axis ? sy : sx) + int'($urandom_range(2 * int'(slop_limit) + 4))
                        - int'(slop_limit) - 2;
                    if (p < 0)
                        p = 0;
                    if (p > MAX_COORD)
                        p = MAX_COORD;
                    send_event(axis ? clpd_pkg::OP_POS_Y : clpd_pkg::OP_POS_X, COORD_W'(p),
                               now_ms + TIME_W'($urandom_range(50)), 1'($urandom_range(1)));
                end
                delta = int'(hold_min) + int'($urandom_range(64)) - 32;
                if (delta < 0)
                    delta = 0;
                now_ms = now_ms + TIME_W'(delta);
                send_event(clpd_pkg::OP_TOUCH_UP, COORD_W'($urandom_range(MAX_COORD)), now_ms,
                           1'($urandom_range(9) != 0));
                sent += 4 + moves;
            end
            else
            begin
                op = clpd_pkg::op_t'($urandom_range(7));
                if ($urandom_range(3) == 0)
                    now_ms = $urandom();
                send_event(op, COORD_W'($urandom_range(MAX_COORD)),
                           $urandom_range(1) ? now_ms : $urandom(), 1'($urandom_range(1)));
                if (op <= clpd_pkg::OP_TOUCH_UP)
                    sent++;
            end
        end
    endtask

    // random phases under several register settings
    task automatic test_config_sweep();
        // reset values written back, no idling on either side
        in_idle_pct = 0;
        out_idle_pct = 0;
        apply_settings(clpd_pkg::HOLD_MIN_MS_RST, clpd_pkg::SLOP_LIMIT_RST,
                       clpd_pkg::REGION_X_MAX_RST, clpd_pkg::REGION_Y_MAX_RST,
                       clpd_pkg::COOLDOWN_MS_RST);
        run_gestures(250);
        in_idle_pct = 34;
        out_idle_pct = 34;
        // lower extremes
        apply_settings('0, '0, '0, '0, '0);
        run_gestures(250);
        // upper extremes
        apply_settings('1, '1, '1, '1, '1);
        run_gestures(250);
        repeat (5)
        begin
            apply_settings(clpd_pkg::ms_t'($urandom_range(2000)),
                           clpd_pkg::limit_t'($urandom_range(100)),
                           clpd_pkg::limit_t'($urandom_range(MAX_COORD)),
                           clpd_pkg::limit_t'($urandom_range(MAX_COORD)),
                           clpd_pkg::ms_t'($urandom_range(3000)));
            run_gestures(120);
            drain_results();
            run_gestures(130);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        logic want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (fire_expected.size() == 0)
            begin
                $display("%0t: unexpected result transaction, actual fire %0b",
                         $time, m_axis_tdata[0]);
                mismatch_count++;
            end
            else
            begin
                want = fire_expected.pop_front();
                if (m_axis_tdata[0] !== want)
                begin
                    $display("%0t: fire mismatch, expected %0b actual %0b",
                             $time, want, m_axis_tdata[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // random back pressure on results
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= out_idle_pct);

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unknown_position();
        test_first_fire_cooldown();
        test_ignored_ops();
        test_release_unpressed();
        test_restart_press();
        test_slop();
        test_time_wrap();
        test_config_sweep();
        drain_results();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
